// ===== hw/rtl/rmts_pkg.sv =====
`default_nettype none

package rmts_pkg;

  // Width of the time, burst and period fields.
  localparam int unsigned TimeW = 16;

  // Width of the task index at the ports.
  localparam int unsigned PortIdxW = 3;

  // Input item kinds.
  localparam logic KindTick = 1'b0;
  localparam logic KindLoad = 1'b1;

  // One entry of the task table, as held in the table memory.
  typedef struct packed {
    logic [TimeW-1:0] period;
    logic [TimeW-1:0] burst;
    logic [TimeW-1:0] rem;
    logic [TimeW-1:0] phase;
  } task_rec_t;

  // One result beat.
  typedef struct packed {
    logic [PortIdxW-1:0] running_task;
    logic                cpu_idle;
    logic                segment_start;
    logic [TimeW-1:0]    tick_time;
  } result_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    StIdle   = 3'b001,
    StSweep  = 3'b010,
    StFinish = 3'b100
  } seq_state_e;

endpackage

`default_nettype wire

// ===== hw/rtl/rmts_task_mem.sv =====
`default_nettype none

module rmts_task_mem
  import rmts_pkg::*;
#(
  parameter int unsigned Depth = 8,
  parameter int unsigned AddrW = 3
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire task_rec_t        wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output task_rec_t             rdata_o
);

  task_rec_t mem_q [Depth];
  task_rec_t rdata_q;

  // One write port; entries hold nothing meaningful until loaded.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // One read port with registered data.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== hw/rtl/rmts_out_reg.sv =====
`default_nettype none

module rmts_out_reg
  import rmts_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    push_i,
  input  wire result_t data_i,
  output logic         free_o,
  output logic         valid_o,
  input  wire logic    stall_i,
  output result_t      data_o
);

  logic    valid_q, valid_d;
  result_t data_q;

  // The slot may be refilled when empty or when its beat leaves now.
  assign free_o = !valid_q || !stall_i;

  always_comb begin
    valid_d = valid_q;
    if (push_i) begin
      valid_d = 1'b1;
    end else if (!stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload holds while stalled, since a push only happens when free.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      data_q <= data_i;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

`default_nettype wire

// ===== hw/rtl/rate_monotonic_tick_scheduler.sv =====
// Channel  Handshake               Beat contents
// in       in_valid_i / in_stall_o kind, task_index, burst_time, period_time
// out      out_valid_o/ out_stall_i running_task, cpu_idle, segment_start, tick_time
//
// A load beat is written to the table in the idle state. A tick beat is accepted,
// then sweeps one table entry per cycle through the table memory's read and
// write ports, then charges the selected task and issues the result.
// Reset clears the valid bits, the tick counter and the run history; table
// entries are only used once loaded. A tick whose result finds the output
// register still stalled waits in its final cycle until the register frees.
`default_nettype none

module rate_monotonic_tick_scheduler
  import rmts_pkg::*;
#(
  parameter int unsigned TASKS = 8
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire logic                kind_i,
  input  wire logic [PortIdxW-1:0] task_index_i,
  input  wire logic [TimeW-1:0]    burst_time_i,
  input  wire logic [TimeW-1:0]    period_time_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output logic [PortIdxW-1:0]      running_task_o,
  output logic                     cpu_idle_o,
  output logic                     segment_start_o,
  output logic [TimeW-1:0]         tick_time_o
);

  localparam int unsigned IdxW = (TASKS > 1) ? $clog2(TASKS) : 1;
  localparam int unsigned CntW = $clog2(TASKS + 1);
  localparam int unsigned ExtW = IdxW + PortIdxW;

  seq_state_e state_q, state_d;

  logic [TASKS-1:0]    valid_q, valid_d;
  logic [CntW-1:0]     rd_cnt_q, rd_cnt_d;
  logic [IdxW-1:0]     data_idx_q, data_idx_d;
  logic [TimeW-1:0]    tick_q, tick_d;
  logic [PortIdxW-1:0] prev_task_q, prev_task_d;
  logic                prev_busy_q, prev_busy_d;
  logic                prev_fin_q, prev_fin_d;
  logic                found_q, found_d;
  logic [IdxW-1:0]     best_idx_q, best_idx_d;
  task_rec_t           best_rec_q, best_rec_d;
  logic                best_rel_q, best_rel_d;

  logic            accept;
  logic            mem_we, mem_re;
  logic [IdxW-1:0] mem_waddr, mem_raddr;
  task_rec_t       mem_wdata, mem_rdata;

  logic            out_push, out_free;
  result_t         out_data, res;

  logic [ExtW-1:0] load_ext, best_ext;
  logic [IdxW-1:0] load_addr;
  logic            load_ok;

  task_rec_t        upd_rec;
  logic             upd_rel;
  logic [TimeW:0]   phase_inc;
  logic [TimeW-1:0] rem_dec;
  logic [PortIdxW-1:0] best_port;
  logic             last_read;

  assign accept     = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != StIdle);

  // Slot address of a load; slots beyond the table are dropped.
  assign load_ext  = ExtW'(task_index_i);
  assign load_addr = load_ext[IdxW-1:0];
  assign load_ok   = (32'(task_index_i) < TASKS);

  // Release and phase update of the entry whose read data is arriving.
  assign phase_inc = {1'b0, mem_rdata.phase} + 1'b1;
  always_comb begin
    upd_rel        = (mem_rdata.phase == '0);
    upd_rec        = mem_rdata;
    upd_rec.rem    = upd_rel ? mem_rdata.burst : mem_rdata.rem;
    upd_rec.phase  = (phase_inc >= {1'b0, mem_rdata.period}) ? '0 : phase_inc[TimeW-1:0];
  end

  // Selected task, charged one unit of work.
  assign rem_dec   = best_rec_q.rem - 1'b1;
  assign best_ext  = ExtW'(best_idx_q);
  assign best_port = best_ext[PortIdxW-1:0];
  assign last_read = (rd_cnt_q == CntW'(TASKS));

  // Result of the finishing tick.
  always_comb begin
    res.tick_time = tick_q;
    if (found_q) begin
      res.running_task  = best_port;
      res.cpu_idle      = 1'b0;
      res.segment_start = !prev_busy_q || prev_fin_q || best_rel_q ||
                          (best_port != prev_task_q);
    end else begin
      res.running_task  = '0;
      res.cpu_idle      = 1'b1;
      res.segment_start = 1'b1;
    end
  end

  // Sequencer: loads, the table sweep and the final charge.
  always_comb begin
    state_d     = state_q;
    valid_d     = valid_q;
    rd_cnt_d    = rd_cnt_q;
    data_idx_d  = data_idx_q;
    tick_d      = tick_q;
    prev_task_d = prev_task_q;
    prev_busy_d = prev_busy_q;
    prev_fin_d  = prev_fin_q;
    found_d     = found_q;
    best_idx_d  = best_idx_q;
    best_rec_d  = best_rec_q;
    best_rel_d  = best_rel_q;
    mem_we      = 1'b0;
    mem_waddr   = load_addr;
    mem_wdata   = '0;
    mem_re      = 1'b0;
    mem_raddr   = '0;
    out_push    = 1'b0;
    out_data    = res;

    case (state_q)
      StIdle: begin
        if (accept && kind_i == KindLoad) begin
          // A load restarts the task; it is released on the next tick.
          if (load_ok) begin
            mem_we          = 1'b1;
            mem_waddr       = load_addr;
            mem_wdata.period = (period_time_i == '0) ? TimeW'(1) : period_time_i;
            mem_wdata.burst = burst_time_i;
            mem_wdata.rem   = '0;
            mem_wdata.phase = '0;
            valid_d[load_addr] = 1'b1;
          end
        end else if (accept) begin
          mem_re     = 1'b1;
          mem_raddr  = '0;
          data_idx_d = '0;
          rd_cnt_d   = CntW'(1);
          found_d    = 1'b0;
          state_d    = StSweep;
        end
      end

      StSweep: begin
        // Write back the arriving entry and track the shortest period with work left.
        if (valid_q[data_idx_q]) begin
          mem_we    = 1'b1;
          mem_waddr = data_idx_q;
          mem_wdata = upd_rec;
          if (upd_rec.rem != '0 &&
              (!found_q || upd_rec.period < best_rec_q.period)) begin
            found_d    = 1'b1;
            best_idx_d = data_idx_q;
            best_rec_d = upd_rec;
            best_rel_d = upd_rel;
          end
        end
        if (last_read) begin
          state_d = StFinish;
        end else begin
          mem_re     = 1'b1;
          mem_raddr  = rd_cnt_q[IdxW-1:0];
          data_idx_d = rd_cnt_q[IdxW-1:0];
          rd_cnt_d   = rd_cnt_q + 1'b1;
        end
      end

      StFinish: begin
        // Charge the running task, if any, and hand the beat to the output register.
        if (out_free) begin
          out_push = 1'b1;
          tick_d   = tick_q + 1'b1;
          state_d  = StIdle;
          if (found_q) begin
            mem_we        = 1'b1;
            mem_waddr     = best_idx_q;
            mem_wdata     = best_rec_q;
            mem_wdata.rem = rem_dec;
            prev_task_d   = best_port;
            prev_busy_d   = 1'b1;
            prev_fin_d    = (rem_dec == '0);
          end else begin
            prev_task_d = '0;
            prev_busy_d = 1'b0;
            prev_fin_d  = 1'b1;
          end
        end
      end

      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      valid_q     <= '0;
      rd_cnt_q    <= '0;
      data_idx_q  <= '0;
      tick_q      <= '0;
      prev_task_q <= '0;
      prev_busy_q <= 1'b0;
      prev_fin_q  <= 1'b1;
      found_q     <= 1'b0;
    end else begin
      state_q     <= state_d;
      valid_q     <= valid_d;
      rd_cnt_q    <= rd_cnt_d;
      data_idx_q  <= data_idx_d;
      tick_q      <= tick_d;
      prev_task_q <= prev_task_d;
      prev_busy_q <= prev_busy_d;
      prev_fin_q  <= prev_fin_d;
      found_q     <= found_d;
    end
  end

  // Candidate payload needs no reset; it is qualified by the found flag.
  always_ff @(posedge clk_i) begin
    best_idx_q <= best_idx_d;
    best_rec_q <= best_rec_d;
    best_rel_q <= best_rel_d;
  end

  rmts_task_mem #(
    .Depth (TASKS),
    .AddrW (IdxW)
  ) u_task_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  result_t out_q;

  rmts_out_reg u_out_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (out_push),
    .data_i  (out_data),
    .free_o  (out_free),
    .valid_o (out_valid_o),
    .stall_i (out_stall_i),
    .data_o  (out_q)
  );

  assign running_task_o  = out_q.running_task;
  assign cpu_idle_o      = out_q.cpu_idle;
  assign segment_start_o = out_q.segment_start;
  assign tick_time_o     = out_q.tick_time;

endmodule

`default_nettype wire
